// File: src/rbrd_pkg.sv
// shared constants and types for the raw block residual decoder
// no dependencies; used by rbrd_pixel_unit and raw_block_residual_decoder
`default_nettype none

package rbrd_pkg;

    // block geometry
    localparam int BLOCK_PIXELS      = 64;
    localparam int BP_W              = $clog2(BLOCK_PIXELS);
    localparam int MAX_WIDTH         = 8192;
    localparam int DIM_W             = 14;
    localparam int COORD_W           = 13;

    // residual packing
    localparam int MAX_RESIDUAL_BITS = 16;
    localparam int RW_W              = 5;
    localparam int BUF_W             = 24;
    localparam int CNT_W             = 5;
    localparam int PIX_W             = 16;
    localparam int BYTE_W            = 8;

    // configuration port
    localparam int APB_DATA_W        = 32;
    localparam int APB_ADDR_W        = 3;
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;
    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 14'd1920;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 14'd1080;

    // result of the shared extract and add unit
    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [CNT_W-1:0] count_left;
        logic             count_short;
    } unit_out_t;

endpackage

`default_nettype wire

// File: src/rbrd_pixel_unit.sv
// shared extract and add unit: pulls one residual out of the bit buffer
// and adds the parity minimum; depends on rbrd_pkg
`default_nettype none

module rbrd_pixel_unit (
    input  wire logic [rbrd_pkg::BUF_W-1:0] bits,
    input  wire logic [rbrd_pkg::CNT_W-1:0] count,
    input  wire logic [rbrd_pkg::RW_W-1:0]  res_width,
    input  wire logic [rbrd_pkg::PIX_W-1:0] base,
    output rbrd_pkg::unit_out_t             result
);

    logic [rbrd_pkg::CNT_W-1:0] shift_amt;
    logic [rbrd_pkg::BUF_W-1:0] shifted;
    logic [rbrd_pkg::PIX_W:0]   mask_wide;
    logic [rbrd_pkg::PIX_W-1:0] residual;

    // msb-first residual sits just below the remaining bit count
    assign shift_amt = count - res_width;
    assign shifted   = bits >> shift_amt;
    assign mask_wide = ((rbrd_pkg::PIX_W+1)'(1) << res_width) - (rbrd_pkg::PIX_W+1)'(1);
    assign residual  = shifted[rbrd_pkg::PIX_W-1:0] & mask_wide[rbrd_pkg::PIX_W-1:0];

    // modulo 2^16 add and remaining bits after this residual
    assign result.value       = base + residual;
    assign result.count_left  = shift_amt;
    assign result.count_short = shift_amt < res_width;

endmodule

`default_nettype wire

// File: src/raw_block_residual_decoder.sv
// raw block residual decoder: one payload byte per request in, decoded pixels out
// header and tail-high bytes are absorbed while idle; a byte that completes pixels gives
// one pixel per cycle while the output slot is free, through the shared extract and add unit,
// and the next request is taken once its last pixel is registered and the output slot is free
// reset: control cleared, frame_done set, frame size 1920 x 1080, no clearing pass
// depends on rbrd_pkg and rbrd_pixel_unit
`default_nettype none

module raw_block_residual_decoder (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // payload request channel
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [rbrd_pkg::BYTE_W-1:0]        payload_byte,
    input  wire logic                               first_byte,
    // pixel channel
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [rbrd_pkg::PIX_W-1:0]              pixel_value,
    output logic [rbrd_pkg::COORD_W-1:0]            pixel_x,
    output logic [rbrd_pkg::COORD_W-1:0]            pixel_y,
    output logic                                    run_last,
    output logic                                    frame_last,
    output logic                                    width_error,
    // configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [rbrd_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [rbrd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rbrd_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                    pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ZERO,
        ST_RES
    } state_t;

    typedef enum logic [2:0] {
        HDR_WIDTH,
        HDR_EVEN_HI,
        HDR_EVEN_LO,
        HDR_ODD_HI,
        HDR_ODD_LO,
        HDR_DATA
    } hdr_phase_t;

    state_t                          state_reg;
    hdr_phase_t                      hdr_reg;
    logic                            tail_phase_reg;
    logic [rbrd_pkg::BYTE_W-1:0]     tail_high_reg;
    logic [rbrd_pkg::RW_W-1:0]       rwidth_reg;
    logic                            blk_err_reg;
    logic [rbrd_pkg::PIX_W-1:0]      even_min_reg;
    logic [rbrd_pkg::PIX_W-1:0]      odd_min_reg;
    logic [rbrd_pkg::BUF_W-1:0]      buf_reg;
    logic [rbrd_pkg::CNT_W-1:0]      cnt_reg;
    logic [rbrd_pkg::BP_W-1:0]       bp_reg;
    logic [rbrd_pkg::DIM_W-1:0]      col_reg;
    logic [rbrd_pkg::DIM_W-1:0]      row_reg;
    logic                            frame_done_reg;
    logic [rbrd_pkg::DIM_W-1:0]      cfg_width_reg;
    logic [rbrd_pkg::DIM_W-1:0]      cfg_height_reg;

    logic                            out_valid_reg;
    logic [rbrd_pkg::PIX_W-1:0]      pixel_value_reg;
    logic [rbrd_pkg::COORD_W-1:0]    pixel_x_reg;
    logic [rbrd_pkg::COORD_W-1:0]    pixel_y_reg;
    logic                            run_last_reg;
    logic                            frame_last_reg;
    logic                            width_error_reg;

    logic [rbrd_pkg::DIM_W-1:0]      width_eff;
    logic [rbrd_pkg::DIM_W-1:0]      height_eff;
    logic                            slot_free;
    logic                            accept;
    logic                            cfg_write;
    hdr_phase_t                      eff_hdr;
    logic                            eff_tail;
    logic [rbrd_pkg::DIM_W-1:0]      eff_col;
    logic                            eff_done;
    logic                            tail_start;
    logic [rbrd_pkg::CNT_W-1:0]      cnt_plus_byte;
    logic                            blk_last;

    logic [rbrd_pkg::PIX_W-1:0]      unit_base;
    rbrd_pkg::unit_out_t             unit_res;

    logic                            emit_en;
    logic [rbrd_pkg::PIX_W-1:0]      emit_value;
    logic                            emit_err;
    logic                            emit_last;
    logic                            emit_unit_end;
    logic [rbrd_pkg::DIM_W-1:0]      col_inc;
    logic [rbrd_pkg::DIM_W-1:0]      row_inc;
    logic                            row_wrap;
    logic                            frame_end;

    // register clamp to 1..max width
    always_comb
    begin
        if (cfg_width_reg == '0)
            width_eff = rbrd_pkg::DIM_W'(1);
        else if (cfg_width_reg > rbrd_pkg::DIM_W'(rbrd_pkg::MAX_WIDTH))
            width_eff = rbrd_pkg::DIM_W'(rbrd_pkg::MAX_WIDTH);
        else
            width_eff = cfg_width_reg;

        if (cfg_height_reg == '0)
            height_eff = rbrd_pkg::DIM_W'(1);
        else if (cfg_height_reg > rbrd_pkg::DIM_W'(rbrd_pkg::MAX_WIDTH))
            height_eff = rbrd_pkg::DIM_W'(rbrd_pkg::MAX_WIDTH);
        else
            height_eff = cfg_height_reg;
    end

    // handshakes
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    // register read
    always_comb
    begin
        case (paddr[2])
            rbrd_pkg::REG_FRAME_WIDTH:
                prdata = {{(rbrd_pkg::APB_DATA_W-rbrd_pkg::DIM_W){1'b0}}, cfg_width_reg};
            rbrd_pkg::REG_FRAME_HEIGHT:
                prdata = {{(rbrd_pkg::APB_DATA_W-rbrd_pkg::DIM_W){1'b0}}, cfg_height_reg};
            default:
                prdata = '0;
        endcase
    end

    // position as seen by this request, after a frame restart
    assign eff_hdr    = first_byte ? HDR_WIDTH : hdr_reg;
    assign eff_tail   = first_byte ? 1'b0 : tail_phase_reg;
    assign eff_col    = first_byte ? '0 : col_reg;
    assign eff_done   = first_byte ? 1'b0 : frame_done_reg;
    assign tail_start = (eff_hdr == HDR_WIDTH) && !eff_tail &&
                        (({1'b0, eff_col} + (rbrd_pkg::DIM_W+1)'(rbrd_pkg::BLOCK_PIXELS))
                         > {1'b0, width_eff});
    assign cnt_plus_byte = cnt_reg + rbrd_pkg::CNT_W'(rbrd_pkg::BYTE_W);
    assign blk_last      = bp_reg == rbrd_pkg::BP_W'(rbrd_pkg::BLOCK_PIXELS - 1);

    // shared extract and add
    assign unit_base = bp_reg[0] ? odd_min_reg : even_min_reg;

    rbrd_pixel_unit u_pixel_unit (
        .bits      (buf_reg),
        .count     (cnt_reg),
        .res_width (rwidth_reg),
        .base      (unit_base),
        .result    (unit_res)
    );

    // pixel emission select
    always_comb
    begin
        emit_en       = 1'b0;
        emit_value    = unit_res.value;
        emit_err      = blk_err_reg;
        emit_last     = 1'b0;
        emit_unit_end = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !eff_done && !tail_start && eff_tail)
                begin
                    emit_en       = 1'b1;
                    emit_value    = {tail_high_reg, payload_byte};
                    emit_err      = 1'b0;
                    emit_last     = 1'b1;
                    emit_unit_end = 1'b1;
                end
            end
            ST_ZERO:
            begin
                emit_en       = slot_free;
                emit_last     = blk_last;
                emit_unit_end = blk_last;
            end
            ST_RES:
            begin
                emit_en       = slot_free;
                emit_last     = blk_last || unit_res.count_short;
                emit_unit_end = blk_last;
            end
            default:
            begin
                emit_en = 1'b0;
            end
        endcase
    end

    // row and frame boundary
    assign col_inc   = col_reg + rbrd_pkg::DIM_W'(1);
    assign row_inc   = row_reg + rbrd_pkg::DIM_W'(1);
    assign row_wrap  = col_inc >= width_eff;
    assign frame_end = row_inc >= height_eff;

    // sequencer, position state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            hdr_reg         <= HDR_WIDTH;
            tail_phase_reg  <= 1'b0;
            tail_high_reg   <= '0;
            rwidth_reg      <= '0;
            blk_err_reg     <= 1'b0;
            even_min_reg    <= '0;
            odd_min_reg     <= '0;
            buf_reg         <= '0;
            cnt_reg         <= '0;
            bp_reg          <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            frame_done_reg  <= 1'b1;
            cfg_width_reg   <= rbrd_pkg::FRAME_WIDTH_RST;
            cfg_height_reg  <= rbrd_pkg::FRAME_HEIGHT_RST;
            out_valid_reg   <= 1'b0;
            pixel_value_reg <= '0;
            pixel_x_reg     <= '0;
            pixel_y_reg     <= '0;
            run_last_reg    <= 1'b0;
            frame_last_reg  <= 1'b0;
            width_error_reg <= 1'b0;
        end
        else
        begin
            // configuration writes
            if (cfg_write)
            begin
                case (paddr[2])
                    rbrd_pkg::REG_FRAME_WIDTH:  cfg_width_reg  <= pwdata[rbrd_pkg::DIM_W-1:0];
                    rbrd_pkg::REG_FRAME_HEIGHT: cfg_height_reg <= pwdata[rbrd_pkg::DIM_W-1:0];
                    default:                    cfg_width_reg  <= cfg_width_reg;
                endcase
            end

            // drained output slot
            if (slot_free)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        // frame restart
                        if (first_byte)
                        begin
                            hdr_reg        <= HDR_WIDTH;
                            tail_phase_reg <= 1'b0;
                            col_reg        <= '0;
                            row_reg        <= '0;
                            frame_done_reg <= 1'b0;
                            bp_reg         <= '0;
                            cnt_reg        <= '0;
                            buf_reg        <= '0;
                            blk_err_reg    <= 1'b0;
                        end
                        if (!eff_done)
                        begin
                            if (tail_start)
                            begin
                                tail_high_reg  <= payload_byte;
                                tail_phase_reg <= 1'b1;
                            end
                            else if (eff_tail)
                            begin
                                tail_phase_reg <= 1'b0;
                            end
                            else
                            begin
                                case (eff_hdr)
                                    HDR_WIDTH:
                                    begin
                                        if (payload_byte >
                                            rbrd_pkg::BYTE_W'(rbrd_pkg::MAX_RESIDUAL_BITS))
                                        begin
                                            rwidth_reg  <= rbrd_pkg::RW_W'(rbrd_pkg::MAX_RESIDUAL_BITS);
                                            blk_err_reg <= 1'b1;
                                        end
                                        else
                                        begin
                                            rwidth_reg  <= payload_byte[rbrd_pkg::RW_W-1:0];
                                            blk_err_reg <= 1'b0;
                                        end
                                        hdr_reg <= HDR_EVEN_HI;
                                    end
                                    HDR_EVEN_HI:
                                    begin
                                        even_min_reg <= {payload_byte, rbrd_pkg::BYTE_W'(0)};
                                        hdr_reg      <= HDR_EVEN_LO;
                                    end
                                    HDR_EVEN_LO:
                                    begin
                                        even_min_reg <= {even_min_reg[rbrd_pkg::PIX_W-1:rbrd_pkg::BYTE_W],
                                                         payload_byte};
                                        hdr_reg      <= HDR_ODD_HI;
                                    end
                                    HDR_ODD_HI:
                                    begin
                                        odd_min_reg <= {payload_byte, rbrd_pkg::BYTE_W'(0)};
                                        hdr_reg     <= HDR_ODD_LO;
                                    end
                                    HDR_ODD_LO:
                                    begin
                                        odd_min_reg <= {odd_min_reg[rbrd_pkg::PIX_W-1:rbrd_pkg::BYTE_W],
                                                        payload_byte};
                                        hdr_reg     <= HDR_DATA;
                                        buf_reg     <= '0;
                                        cnt_reg     <= '0;
                                        bp_reg      <= '0;
                                        // zero width: minimums only
                                        if (rwidth_reg == '0)
                                            state_reg <= ST_ZERO;
                                    end
                                    HDR_DATA:
                                    begin
                                        buf_reg <= {buf_reg[rbrd_pkg::BUF_W-rbrd_pkg::BYTE_W-1:0],
                                                    payload_byte};
                                        cnt_reg <= cnt_plus_byte;
                                        if (cnt_plus_byte >= rwidth_reg)
                                            state_reg <= ST_RES;
                                    end
                                    default:
                                    begin
                                        hdr_reg <= HDR_WIDTH;
                                    end
                                endcase
                            end
                        end
                    end
                end
                ST_ZERO:
                begin
                    if (slot_free)
                    begin
                        bp_reg <= bp_reg + rbrd_pkg::BP_W'(1);
                        if (blk_last)
                        begin
                            hdr_reg   <= HDR_WIDTH;
                            bp_reg    <= '0;
                            buf_reg   <= '0;
                            cnt_reg   <= '0;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_RES:
                begin
                    if (slot_free)
                    begin
                        cnt_reg <= unit_res.count_left;
                        bp_reg  <= bp_reg + rbrd_pkg::BP_W'(1);
                        if (blk_last)
                        begin
                            // leftover bits are dropped
                            hdr_reg <= HDR_WIDTH;
                            bp_reg  <= '0;
                            buf_reg <= '0;
                            cnt_reg <= '0;
                        end
                        if (blk_last || unit_res.count_short)
                            state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // pixel into output register, column advance, row and frame end
            if (emit_en)
            begin
                out_valid_reg   <= 1'b1;
                pixel_value_reg <= emit_value;
                pixel_x_reg     <= col_reg[rbrd_pkg::COORD_W-1:0];
                pixel_y_reg     <= row_reg[rbrd_pkg::COORD_W-1:0];
                run_last_reg    <= emit_last;
                width_error_reg <= emit_err;
                frame_last_reg  <= emit_unit_end && row_wrap && frame_end;
                col_reg         <= col_inc;
                if (emit_unit_end && row_wrap)
                begin
                    col_reg <= '0;
                    row_reg <= row_inc;
                    if (frame_end)
                        frame_done_reg <= 1'b1;
                end
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_value = pixel_value_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign run_last    = run_last_reg;
    assign frame_last  = frame_last_reg;
    assign width_error = width_error_reg;

    // the frame always ends on the last pixel of a request
    a_frame_last_is_run_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && frame_last) |-> run_last
    ) else $error("frame_last without run_last");

    // once the last pixel of a frame is out, further bytes are ignored until a restart
    a_frame_done_after_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && frame_last && !(in_valid && in_ready && first_byte))
        |=> frame_done_reg
    ) else $error("frame not closed after its last pixel");

    // residual extraction only runs with a full residual in the buffer
    a_res_has_bits: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RES) |-> (cnt_reg >= rwidth_reg)
    ) else $error("residual extraction short of bits");

endmodule

`default_nettype wire

// File: sim/raw_block_residual_decoder_tb.sv
// self-checking testbench for raw_block_residual_decoder: random and directed payload
// requests, a pixel predictor in a scoreboard class, frame size changes over the apb port
// depends on rbrd_pkg and the decoder rtl
`default_nettype none

module raw_block_residual_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rbrd_pkg::*;

    localparam int LONG_STALL_CYCLES = 300;
    localparam int SETTLE_CYCLES     = 8;
    localparam int DRAIN_CYCLES      = 70;
    localparam int DRAIN_LIMIT       = 20000;
    localparam int NUM_PHASES        = 6;
    localparam int NUM_DIRECTED      = 26;

    // position inside a block header, then residual data
    typedef enum bit [2:0] {
        HDR_WIDTH   = 3'd0,
        HDR_EVEN_HI = 3'd1,
        HDR_EVEN_LO = 3'd2,
        HDR_ODD_HI  = 3'd3,
        HDR_ODD_LO  = 3'd4,
        HDR_DATA    = 3'd5
    } hdr_phase_e;

    typedef struct packed {
        logic [PIX_W-1:0]   value;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               run_last;
        logic               frame_last;
        logic               werr;
    } pixel_t;

    // pixel predictor and checker
    class pixel_scoreboard;
        logic [DIM_W-1:0] width_cfg;
        logic [DIM_W-1:0] height_cfg;
        hdr_phase_e       hdr_phase;
        bit [RW_W-1:0]    res_width;
        bit [PIX_W-1:0]   even_min;
        bit [PIX_W-1:0]   odd_min;
        bit [BUF_W-1:0]   bit_buf;
        bit [CNT_W-1:0]   bit_cnt;
        bit [BP_W:0]      blk_pix;
        int unsigned      col;
        int unsigned      row;
        bit [BYTE_W-1:0]  tail_hi;
        bit               tail_ph;
        bit               frame_done;
        bit               blk_err;
        pixel_t           expected_pixels[$];
        pixel_t           held;
        bit               have_held;
        bit               frame_hit;
        int               mismatches;
        int               bytes_seen;
        int               bytes_ignored;
        int               pixels_seen;
        int               frames_closed;

        function new();
            width_cfg  = FRAME_WIDTH_RST;
            height_cfg = FRAME_HEIGHT_RST;
            clear_position();
            frame_done = 1'b1;
        endfunction

        function void clear_position();
            hdr_phase = HDR_WIDTH;
            res_width = '0;
            even_min  = '0;
            odd_min   = '0;
            bit_buf   = '0;
            bit_cnt   = '0;
            blk_pix   = '0;
            col       = 0;
            row       = 0;
            tail_hi   = '0;
            tail_ph   = 1'b0;
            blk_err   = 1'b0;
        endfunction

        // zero acts as one, anything above the maximum acts as the maximum
        function int unsigned dim(logic [DIM_W-1:0] v);
            if (v == 0)
                return 1;
            if (v > MAX_WIDTH)
                return MAX_WIDTH;
            return v;
        endfunction

        function void set_dim(logic idx, logic [DIM_W-1:0] value);
            if (idx == REG_FRAME_WIDTH)
                width_cfg = value;
            else
                height_cfg = value;
        endfunction

        // true when the next request will be taken as a block width byte
        function bit width_byte_next(bit restart);
            if (restart)
                return dim(width_cfg) >= BLOCK_PIXELS;
            return !frame_done && hdr_phase == HDR_WIDTH && !tail_ph &&
                   col + BLOCK_PIXELS <= dim(width_cfg);
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        // last pixel of a request is held back until its flags are known
        function void emit(bit [PIX_W-1:0] v, bit e);
            if (have_held)
                expected_pixels.push_back(held);
            held.value      = v;
            held.x          = COORD_W'(col);
            held.y          = COORD_W'(row);
            held.run_last   = 1'b0;
            held.frame_last = 1'b0;
            held.werr       = e;
            have_held       = 1'b1;
            col++;
        endfunction

        // row and frame wrap at a block or tail word boundary
        function void unit_end();
            if (col >= dim(width_cfg))
            begin
                col = 0;
                row++;
                if (row >= dim(height_cfg))
                begin
                    frame_done = 1'b1;
                    frame_hit  = 1'b1;
                end
            end
        endfunction

        function void block_end();
            hdr_phase = HDR_WIDTH;
            blk_pix   = '0;
            bit_buf   = '0;
            bit_cnt   = '0;
            unit_end();
        endfunction

        function void note_request(bit [BYTE_W-1:0] b, bit restart);
            int unsigned w;
            int unsigned res;
            bytes_seen++;
            have_held = 1'b0;
            frame_hit = 1'b0;
            if (restart)
            begin
                clear_position();
                frame_done = 1'b0;
            end
            if (frame_done)
            begin
                bytes_ignored++;
                return;
            end
            if (hdr_phase == HDR_WIDTH && !tail_ph && col + BLOCK_PIXELS > dim(width_cfg))
            begin
                tail_hi = b;
                tail_ph = 1'b1;
            end
            else if (tail_ph)
            begin
                emit({tail_hi, b}, 1'b0);
                tail_ph = 1'b0;
                unit_end();
            end
            else
            begin
                case (hdr_phase)
                    HDR_WIDTH:
                    begin
                        blk_err   = b > MAX_RESIDUAL_BITS;
                        res_width = blk_err ? RW_W'(MAX_RESIDUAL_BITS) : b[RW_W-1:0];
                        hdr_phase = HDR_EVEN_HI;
                    end
                    HDR_EVEN_HI:
                    begin
                        even_min  = {b, 8'h00};
                        hdr_phase = HDR_EVEN_LO;
                    end
                    HDR_EVEN_LO:
                    begin
                        even_min[7:0] = b;
                        hdr_phase     = HDR_ODD_HI;
                    end
                    HDR_ODD_HI:
                    begin
                        odd_min   = {b, 8'h00};
                        hdr_phase = HDR_ODD_LO;
                    end
                    HDR_ODD_LO:
                    begin
                        odd_min[7:0] = b;
                        hdr_phase    = HDR_DATA;
                        bit_buf      = '0;
                        bit_cnt      = '0;
                        blk_pix      = '0;
                        // zero width: the minimums alone, right away
                        if (res_width == 0)
                        begin
                            while (blk_pix < BLOCK_PIXELS)
                            begin
                                emit(blk_pix[0] ? odd_min : even_min, blk_err);
                                blk_pix++;
                            end
                            block_end();
                        end
                    end
                    default:
                    begin
                        // unpack msb-first residuals as far as the buffered bits go
                        w       = res_width;
                        bit_buf = {bit_buf[BUF_W-9:0], b};
                        bit_cnt = bit_cnt + 8;
                        while (bit_cnt >= w && blk_pix < BLOCK_PIXELS)
                        begin
                            res     = (bit_buf >> (bit_cnt - w)) & ((1 << w) - 1);
                            bit_cnt = bit_cnt - w;
                            emit(PIX_W'((blk_pix[0] ? odd_min : even_min) + res), blk_err);
                            blk_pix++;
                        end
                        if (blk_pix >= BLOCK_PIXELS)
                            block_end();
                    end
                endcase
            end
            if (have_held)
            begin
                held.run_last   = 1'b1;
                held.frame_last = frame_hit;
                expected_pixels.push_back(held);
                if (frame_hit)
                    frames_closed++;
            end
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR at %0t: %s", $time, msg);
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            pixels_seen++;
            if (expected_pixels.size() == 0)
            begin
                flag($sformatf("unexpected pixel %h at (%0d,%0d)", got.value, got.x, got.y));
                return;
            end
            want = expected_pixels.pop_front();
            if (got.value !== want.value || got.x !== want.x || got.y !== want.y ||
                got.run_last !== want.run_last || got.frame_last !== want.frame_last ||
                got.werr !== want.werr)
                flag($sformatf({"pixel expected %h (%0d,%0d) run_last %b frame_last %b ",
                                "width_error %b, got %h (%0d,%0d) %b %b %b"},
                               want.value, want.x, want.y, want.run_last, want.frame_last,
                               want.werr, got.value, got.x, got.y, got.run_last,
                               got.frame_last, got.werr));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [BYTE_W-1:0]     payload_byte;
    logic                  first_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic [PIX_W-1:0]      pixel_value;
    logic [COORD_W-1:0]    pixel_x;
    logic [COORD_W-1:0]    pixel_y;
    logic                  run_last;
    logic                  frame_last;
    logic                  width_error;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    pixel_scoreboard sb;
    bit              no_idle;
    bit              stall_request;
    int              long_stalls;
    int              settings_used;

    // {first_byte, payload_byte}: an ignored byte, a width-one block with wrapping sums,
    // a clamped-width block cut short by a restart into a zero-width block
    bit [8:0] directed_req [NUM_DIRECTED] = '{
        9'h055,
        9'h101, 9'h0FF, 9'h0FF, 9'h080, 9'h000,
        9'h0FF, 9'h000, 9'h0FF, 9'h000, 9'h0FF, 9'h000, 9'h0FF, 9'h000,
        9'h011, 9'h000, 9'h000, 9'h0FF, 9'h0FF, 9'h0FF, 9'h000,
        9'h100, 9'h0FF, 9'h0FF, 9'h000, 9'h000
    };

    // frame sizes per phase, zero and out-of-range values included
    int phase_width  [NUM_PHASES] = '{70, 0, 16383, 1, 128, 65};
    int phase_height [NUM_PHASES] = '{2, 3, 16383, 0, 1, 2};
    int phase_items  [NUM_PHASES] = '{28, 14, 20, 12, 20, 20};

    raw_block_residual_decoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .payload_byte (payload_byte),
        .first_byte   (first_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_value  (pixel_value),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .run_last     (run_last),
        .frame_last   (frame_last),
        .width_error  (width_error),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // pixel receiver: short random stalls, one long stall on request
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                out_ready = 1'b0;
                repeat (LONG_STALL_CYCLES) @(negedge clk);
                stall_request = 1'b0;
                long_stalls++;
            end
            else if (!no_idle && $urandom_range(0, 4) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge clk);
            end
            else
                out_ready = 1'b1;
        end
    end

    // pixel monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_pixel({pixel_value, pixel_x, pixel_y, run_last, frame_last, width_error});
    end

    // one payload request, called at a falling edge; valid stays up unless a gap follows
    task automatic send_byte(bit [BYTE_W-1:0] b, bit restart);
        in_valid     = 1'b1;
        payload_byte = b;
        first_byte   = restart;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(b, restart);
        @(negedge clk);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
    endtask

    // mostly small residual widths, some wide ones, a few that get clamped
    function automatic bit [BYTE_W-1:0] pick_width();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return $urandom_range(0, 3);
        if (r < 75)
            return $urandom_range(4, 8);
        if (r < 93)
            return $urandom_range(9, MAX_RESIDUAL_BITS);
        return $urandom_range(MAX_RESIDUAL_BITS + 1, 255);
    endfunction

    // well-formed payload with random content, odd restarts and bytes between frames
    task automatic random_run(int count);
        int              sent;
        bit              restart;
        bit [BYTE_W-1:0] b;
        sent = 0;
        while (sent < count)
        begin
            if (sb.frame_done)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
                restart = 1'b1;
            end
            else
                restart = ($urandom_range(0, 39) == 0);
            b = sb.width_byte_next(restart) ? pick_width() : BYTE_W'($urandom_range(0, 255));
            send_byte(b, restart);
            sent++;
        end
    endtask

    task automatic check_reg(logic idx, logic [DIM_W-1:0] value);
        logic [APB_DATA_W-1:0] got;
        paddr   = {idx, 2'b00};
        pwrite  = 1'b0;
        psel    = 1'b1;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (got !== APB_DATA_W'(value))
            sb.flag($sformatf("register %0d read %h, expected %h", idx, got, value));
    endtask

    task automatic write_reg(logic idx, logic [DIM_W-1:0] value);
        paddr   = {idx, 2'b00};
        pwdata  = APB_DATA_W'(value);
        pwrite  = 1'b1;
        psel    = 1'b1;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        sb.set_dim(idx, value);
        check_reg(idx, value);
    endtask

    // wait until every expected pixel is out and the block has gone quiet
    task automatic settle();
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // main sequence
    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        payload_byte  = '0;
        first_byte    = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        no_idle       = 1'b0;
        stall_request = 1'b0;
        sb            = new();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset values of the frame size
        check_reg(REG_FRAME_WIDTH, FRAME_WIDTH_RST);
        check_reg(REG_FRAME_HEIGHT, FRAME_HEIGHT_RST);

        // directed requests at the reset frame size
        foreach (directed_req[i])
            send_byte(directed_req[i][7:0], directed_req[i][8]);

        // random phases, each under its own frame size
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            write_reg(REG_FRAME_WIDTH, DIM_W'(phase_width[p]));
            write_reg(REG_FRAME_HEIGHT, DIM_W'(phase_height[p]));
            settings_used++;
            if (p == 2)
                stall_request = 1'b1;
            if (p == NUM_PHASES - 1)
                no_idle = 1'b1;
            random_run(phase_items[p]);
        end

        // drain
        in_valid = 1'b0;
        for (int i = 0; i < DRAIN_LIMIT && sb.pending() != 0; i++)
            @(negedge clk);
        if (sb.pending() != 0)
            sb.flag($sformatf("%0d expected pixels never arrived", sb.pending()));
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("summary: %0d payload bytes (%0d outside a frame), %0d pixels compared, %0d frames closed",
                 sb.bytes_seen, sb.bytes_ignored, sb.pixels_seen, sb.frames_closed);
        $display("summary: %0d frame size settings, %0d long output stall(s), %0d mismatches",
                 settings_used, long_stalls, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
src/rbrd_pkg.sv
src/rbrd_pixel_unit.sv
src/raw_block_residual_decoder.sv
sim/raw_block_residual_decoder_tb.sv
